/* hdl/kec_pkg.sv */
// shared types and constants for the keying edge clip window block
package kec_pkg;

  // sample and register widths
  localparam int PIX_W      = 16;
  localparam int RAD_CFG_W  = 3;
  localparam int WID_CFG_W  = 12;
  localparam int H_W        = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd6;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_SCAN,
    ST_LAST,
    ST_DECIDE,
    ST_DIV,
    ST_OUT
  } st_t;

  // data handed from one divider cell to the next
  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] num;
    logic [PIX_W-1:0] den;
    logic [PIX_W-1:0] quo;
  } div_cell_t;

endpackage

/* hdl/kec_div_cell.sv */
// one restoring-division cell: resolves one quotient bit and registers it
module kec_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  kec_pkg::div_cell_t prev,
  output kec_pkg::div_cell_t next
);
  import kec_pkg::*;

  logic [PIX_W:0]   sh;
  logic             ge;
  logic [PIX_W:0]   sub;
  div_cell_t        step;

  // shift in the next numerator bit and try the subtract
  always_comb begin
    sh   = {prev.rem, prev.num[PIX_W-1]};
    ge   = sh >= {1'b0, prev.den};
    sub  = sh - {1'b0, prev.den};
    step.vld = prev.vld;
    step.rem = ge ? sub[PIX_W-1:0] : sh[PIX_W-1:0];
    step.num = {prev.num[PIX_W-2:0], 1'b0};
    step.den = prev.den;
    step.quo = {prev.quo[PIX_W-2:0], ge};
  end

  // valid flag and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next.vld <= 1'b0;
    end else begin
      next.vld <= step.vld;
    end
    next.rem <= step.rem;
    next.num <= step.num;
    next.den <= step.den;
    next.quo <= step.quo;
  end

endmodule

/* hdl/keying_edge_clip_window_top.sv */
// top level of the keying edge clip window: line store, window scan, clip and divider chain
//
// Matte samples enter on the in_ channel in raster order; in_tuser marks a flush
// transaction that carries no sample and only drains a pending result after the frame.
// Results leave on the out_ channel, lagging the input by (r-1) rows plus (r-1) pixels;
// out_tlast marks the result of the last pixel of a frame.
// Configuration goes through cfg_wr_en/cfg_addr/cfg_wr_data while the block is idle;
// the user is bound to this, and the block itself does not enforce it. A transaction that
// releases a result runs a window scan that reads one neighbour a cycle from the line
// store, which has one write port and one read port; a flat pixel in clip mode that needs
// rescaling then passes through the chain of divider cells, one quotient bit per cell.
// One transaction is worked on at a time.
// The output register lets a new transaction be accepted while a result waits; when
// out_tready stays low, the next finished result holds in the sequencer and in_tready
// stays low until the output register frees up.
// Reset (rst_n low, synchronous) clears positions, pointers, the pending count and
// loads the register defaults; the line store is not cleared and needs no clearing pass.
module keying_edge_clip_window_top #(
  parameter int MAX_RADIUS = 4,
  parameter int MAX_WIDTH  = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kec_pkg::PIX_W-1:0]          in_tdata,    // pixel
  input  logic                               in_tuser,    // flush
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [kec_pkg::PIX_W-1:0]          out_tdata,   // result_value
  output logic                               out_tlast,
  input  logic                               cfg_wr_en,
  input  logic [kec_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [kec_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
  import kec_pkg::*;

  localparam int LS_DEPTH = 2 * (MAX_RADIUS - 1) * (MAX_WIDTH + 1) + 2;
  localparam int ADDR_W   = $clog2(LS_DEPTH);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int EW       = (WID_W > WID_CFG_W) ? WID_W : WID_CFG_W;
  localparam int R_W      = $clog2(MAX_RADIUS + 1);
  localparam int K_W      = $clog2(2 * MAX_RADIUS);
  localparam int LAG_MAX  = (MAX_RADIUS - 1) * MAX_WIDTH + MAX_RADIUS - 1;
  localparam int PEND_W   = $clog2(LAG_MAX + 2);
  localparam int NB_MAX   = (2 * MAX_RADIUS - 1) * (2 * MAX_RADIUS - 1) - 1;
  localparam int NB_W     = $clog2(NB_MAX + 2);
  localparam int MW       = R_W + WID_W + 1;
  localparam int CX_W     = WID_W + K_W + 1;
  localparam int RY_W     = H_W + K_W + 1;

  // configuration registers
  logic [RAD_CFG_W-1:0] radius_r;
  logic [PIX_W-1:0]     tol_r, black_r, white_r;
  logic                 edge_r;
  logic [WID_CFG_W-1:0] width_r;
  logic [H_W-1:0]       height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_CFG_W'(3);
      tol_r    <= PIX_W'(6554);
      black_r  <= '0;
      white_r  <= PIX_MAX;
      edge_r   <= 1'b0;
      width_r  <= WID_CFG_W'(2048);
      height_r <= H_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_RADIUS:    radius_r <= cfg_wr_data[RAD_CFG_W-1:0];
        REG_TOLERANCE: tol_r    <= cfg_wr_data[PIX_W-1:0];
        REG_BLACK:     black_r  <= cfg_wr_data[PIX_W-1:0];
        REG_WHITE:     white_r  <= cfg_wr_data[PIX_W-1:0];
        REG_EDGE:      edge_r   <= cfg_wr_data[0];
        REG_WIDTH:     width_r  <= cfg_wr_data[WID_CFG_W-1:0];
        REG_HEIGHT:    height_r <= cfg_wr_data[H_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry and radius
  logic [WID_W-1:0] eff_w;
  logic [H_W-1:0]   eff_h;
  logic [R_W-1:0]   r_eff, rr;
  logic [MW-1:0]    lag_full;
  logic [PEND_W-1:0] lag;

  always_comb begin
    if (width_r == '0) begin
      eff_w = WID_W'(1);
    end else if (EW'(width_r) > EW'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(width_r);
    end
    eff_h = (height_r == '0) ? H_W'(1) : height_r;
    if (5'(radius_r) > 5'(MAX_RADIUS)) begin
      r_eff = R_W'(MAX_RADIUS);
    end else begin
      r_eff = R_W'(radius_r);
    end
    rr       = (r_eff == '0) ? '0 : r_eff - R_W'(1);
    lag_full = MW'(rr) * MW'(eff_w) + MW'(rr);
    lag      = PEND_W'(lag_full);
  end

  // sequencer and bookkeeping registers
  st_t                 state_r, state_nxt;
  logic [COL_W-1:0]    in_col_r, out_col_r, cur_col_r;
  logic [H_W-1:0]      in_row_r, out_row_r, cur_row_r;
  logic [ADDR_W-1:0]   wr_ptr_r, rd_ptr_r, cur_rd_r, row_base_r;
  logic [PEND_W-1:0]   pending_r;
  logic [K_W-1:0]      i_r, j_r;
  logic                last_r;
  logic [PIX_W-1:0]    value_r, res_r, rdata_r;
  logic                cmp_vld_r, ctr_take_r;
  logic [NB_W-1:0]     n_r, sim_r;
  logic [PIX_W-1:0]    out_data_r;
  logic                out_last_r, out_tvalid_r;

  logic [PIX_W-1:0] line_store [LS_DEPTH];

  // raster advance for input and output positions
  logic             acc, is_pix, emit;
  logic             in_cwrap, out_cwrap, in_rwrap, out_rwrap;
  logic [PEND_W:0]  pend_inc;

  always_comb begin
    acc       = in_tvalid && in_tready;
    is_pix    = !in_tuser;
    in_cwrap  = (WID_W'(in_col_r) + WID_W'(1)) >= eff_w;
    out_cwrap = (WID_W'(out_col_r) + WID_W'(1)) >= eff_w;
    in_rwrap  = ((H_W + 1)'(in_row_r) + (H_W + 1)'(1)) >= (H_W + 1)'(eff_h);
    out_rwrap = ((H_W + 1)'(out_row_r) + (H_W + 1)'(1)) >= (H_W + 1)'(eff_h);
    pend_inc  = (PEND_W + 1)'(pending_r) + (PEND_W + 1)'(1);
    if (is_pix) begin
      emit = pend_inc > (PEND_W + 1)'(lag);
    end else begin
      emit = (pending_r != '0) && (in_col_r == '0) && (in_row_r == '0);
    end
  end

  // window address walk and bounds
  logic [ADDR_W:0]   sa_full, base_full, rb_full;
  logic [ADDR_W-1:0] scan_addr, base_addr, rb_next;
  logic [MW-1:0]     off_full;
  logic [K_W-1:0]    rr_k, two_rr;
  logic [CX_W-1:0]   cx;
  logic [RY_W-1:0]   ry;
  logic              in_rng, center, nbr_ok, row_end, scan_done;

  always_comb begin
    rr_k      = K_W'(rr);
    two_rr    = K_W'({rr, 1'b0});
    off_full  = MW'(rr) * MW'(eff_w) + MW'(rr);
    base_full = (ADDR_W + 1)'(cur_rd_r) + (ADDR_W + 1)'(LS_DEPTH) - (ADDR_W + 1)'(off_full);
    base_addr = (base_full >= (ADDR_W + 1)'(LS_DEPTH)) ?
                ADDR_W'(base_full - (ADDR_W + 1)'(LS_DEPTH)) : ADDR_W'(base_full);
    sa_full   = (ADDR_W + 1)'(row_base_r) + (ADDR_W + 1)'(j_r);
    scan_addr = (sa_full >= (ADDR_W + 1)'(LS_DEPTH)) ?
                ADDR_W'(sa_full - (ADDR_W + 1)'(LS_DEPTH)) : ADDR_W'(sa_full);
    rb_full   = (ADDR_W + 1)'(row_base_r) + (ADDR_W + 1)'(eff_w);
    rb_next   = (rb_full >= (ADDR_W + 1)'(LS_DEPTH)) ?
                ADDR_W'(rb_full - (ADDR_W + 1)'(LS_DEPTH)) : ADDR_W'(rb_full);
    cx        = CX_W'(cur_col_r) + CX_W'(j_r);
    ry        = RY_W'(cur_row_r) + RY_W'(i_r);
    in_rng    = (cx >= CX_W'(rr)) && (cx < CX_W'(eff_w) + CX_W'(rr)) &&
                (ry >= RY_W'(rr)) && (ry < RY_W'(eff_h) + RY_W'(rr));
    center    = (i_r == rr_k) && (j_r == rr_k);
    nbr_ok    = in_rng && !center;
    row_end   = (j_r == two_rr);
    scan_done = row_end && (i_r == two_rr);
  end

  // flat decision and result selection
  logic              flat;
  logic              div_go;
  logic [PIX_W-1:0]  res_sel, x_sub;
  logic [2*PIX_W-1:0] num_full;
  logic [NB_W+3:0]   sim10, n9;

  always_comb begin
    sim10 = (NB_W + 4)'(sim_r) * (NB_W + 4)'(10);
    n9    = (NB_W + 4)'(n_r) * (NB_W + 4)'(9);
    flat  = (r_eff == '0) || ((n_r != '0) && (sim10 >= n9));
    div_go = 1'b0;
    if (edge_r) begin
      res_sel = flat ? '0 : PIX_MAX;
    end else if (!flat) begin
      res_sel = value_r;
    end else if (value_r < black_r) begin
      res_sel = '0;
    end else if (value_r >= white_r) begin
      res_sel = PIX_MAX;
    end else begin
      res_sel = value_r;
      div_go  = 1'b1;
    end
    x_sub    = value_r - black_r;
    num_full = {x_sub, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, x_sub};
  end

  // divider chain: one cell per quotient bit
  div_cell_t div_in;
  div_cell_t chain [PIX_W+1];

  always_comb begin
    div_in.vld = (state_r == ST_DECIDE) && div_go;
    div_in.rem = num_full[2*PIX_W-1:PIX_W];
    div_in.num = num_full[PIX_W-1:0];
    div_in.den = white_r - black_r;
    div_in.quo = '0;
  end

  assign chain[0] = div_in;

  for (genvar g = 0; g < PIX_W; g++) begin : g_div
    kec_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .prev (chain[g]),
      .next (chain[g+1])
    );
  end

  // next state
  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (acc && emit) state_nxt = ST_CENTER;
      ST_CENTER: state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_done) state_nxt = ST_LAST;
      ST_LAST:   state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = div_go ? ST_DIV : ST_OUT;
      ST_DIV:    if (chain[PIX_W].vld) state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  logic              load_out;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    rd_addr   = scan_addr;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_CENTER: rd_addr = cur_rd_r;
      ST_OUT:    load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (acc && is_pix) begin
      line_store[wr_ptr_r] <= in_tdata;
    end
    rdata_r <= line_store[rd_addr];
  end

  // positions, pointers and pending count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      pending_r <= '0;
    end else if (acc) begin
      if (is_pix) begin
        wr_ptr_r <= ((ADDR_W + 1)'(wr_ptr_r) + (ADDR_W + 1)'(1) >= (ADDR_W + 1)'(LS_DEPTH)) ?
                    '0 : wr_ptr_r + ADDR_W'(1);
        in_col_r <= in_cwrap ? '0 : in_col_r + COL_W'(1);
        if (in_cwrap) begin
          in_row_r <= in_rwrap ? '0 : in_row_r + H_W'(1);
        end
        if (!emit) begin
          pending_r <= PEND_W'(pend_inc);
        end
      end else if (emit) begin
        pending_r <= pending_r - PEND_W'(1);
      end
      if (emit) begin
        rd_ptr_r <= ((ADDR_W + 1)'(rd_ptr_r) + (ADDR_W + 1)'(1) >= (ADDR_W + 1)'(LS_DEPTH)) ?
                    '0 : rd_ptr_r + ADDR_W'(1);
        out_col_r <= out_cwrap ? '0 : out_col_r + COL_W'(1);
        if (out_cwrap) begin
          out_row_r <= out_rwrap ? '0 : out_row_r + H_W'(1);
        end
      end
    end
  end

  // snapshot of the result being worked on
  always_ff @(posedge clk) begin
    if (acc && emit) begin
      cur_col_r <= out_col_r;
      cur_row_r <= out_row_r;
      cur_rd_r  <= rd_ptr_r;
      last_r    <= out_cwrap && out_rwrap;
    end
  end

  // window walk counters
  always_ff @(posedge clk) begin
    if (state_r == ST_CENTER) begin
      row_base_r <= base_addr;
      i_r        <= '0;
      j_r        <= '0;
    end else if (state_r == ST_SCAN) begin
      if (row_end) begin
        j_r        <= '0;
        i_r        <= i_r + K_W'(1);
        row_base_r <= rb_next;
      end else begin
        j_r <= j_r + K_W'(1);
      end
    end
  end

  // compare stage behind the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r  <= 1'b0;
      ctr_take_r <= 1'b0;
    end else begin
      cmp_vld_r  <= (state_r == ST_SCAN) && nbr_ok;
      ctr_take_r <= (state_r == ST_CENTER);
    end
  end

  always_ff @(posedge clk) begin
    if (ctr_take_r) begin
      value_r <= rdata_r;
    end
    if (state_r == ST_CENTER) begin
      n_r   <= '0;
      sim_r <= '0;
    end else if (cmp_vld_r) begin
      n_r <= n_r + NB_W'(1);
      if (((rdata_r > value_r) ? (rdata_r - value_r) : (value_r - rdata_r)) < tol_r) begin
        sim_r <= sim_r + NB_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE) begin
      res_r <= res_sel;
    end else if (state_r == ST_DIV && chain[PIX_W].vld) begin
      res_r <= chain[PIX_W].quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= res_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    chain[PIX_W].vld |-> state_r == ST_DIV)
    else $error("divider result outside divide wait");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PEND_W'(LAG_MAX))
    else $error("pending count beyond store reach");

  a_emit_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit) |=> state_r == ST_CENTER)
    else $error("released result did not start a window scan");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_OUT))
    else $error("output loaded outside output state");

endmodule

/* tb/tb.sv */
// testbench for the keying edge clip window: directed and random frames checked against a flatness predictor
module tb;
  import kec_pkg::*;

  localparam int LS_DEPTH = 2 * (4 - 1) * (2048 + 1) + 2;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } pix_item_t;

  typedef struct {
    logic [PIX_W-1:0] value;
    logic             last;
  } matte_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;    // pixel
  logic                  in_tuser = 1'b0;  // flush
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;        // result_value
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  pix_item_t  pix_queue[$];
  matte_res_t matte_exp[$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;

  // predictor state
  logic [PIX_W-1:0] shadow_store [LS_DEPTH];
  int p_in_col, p_in_row, p_out_col, p_out_row, p_wr, p_rd, p_pending;
  int c_radius, c_tol, c_black, c_white, c_edge, c_width, c_height;

  keying_edge_clip_window_top u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_wr_en, .cfg_addr, .cfg_wr_data
  );

  always #5 clk = ~clk;

  function automatic int eff_w();
    if (c_width == 0) return 1;
    if (c_width > 2048) return 2048;
    return c_width;
  endfunction

  function automatic int eff_h();
    return (c_height == 0) ? 1 : c_height;
  endfunction

  function automatic int eff_lag();
    int r;
    int rr;
    r = (c_radius > 4) ? 4 : c_radius;
    rr = (r > 0) ? r - 1 : 0;
    return rr * eff_w() + rr;
  endfunction

  function automatic void step_pos(ref int col, ref int row, input int w, input int h);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  // flatness test and clip for one accepted transaction
  function automatic void predict_matte(logic [PIX_W-1:0] px, logic fl);
    int w, h, r, rr, lag, n, similar, ry, cx, addr, nb, diff, value;
    bit emit, flat;
    longint unsigned q;
    matte_res_t res;
    w = eff_w();
    h = eff_h();
    r = (c_radius > 4) ? 4 : c_radius;
    rr = (r > 0) ? r - 1 : 0;
    lag = rr * w + rr;
    if (!fl) begin
      shadow_store[p_wr] = px;
      p_wr = (p_wr + 1 >= LS_DEPTH) ? 0 : p_wr + 1;
      p_pending++;
      step_pos(p_in_col, p_in_row, w, h);
      emit = p_pending > lag;
    end else begin
      emit = p_pending > 0 && p_in_col == 0 && p_in_row == 0;
    end
    if (!emit) return;
    value = shadow_store[p_rd];
    flat = (r == 0);
    if (!flat) begin
      n = 0;
      similar = 0;
      for (int dy = -rr; dy <= rr; dy++) begin
        for (int dx = -rr; dx <= rr; dx++) begin
          ry = p_out_row + dy;
          cx = p_out_col + dx;
          if (dy == 0 && dx == 0) continue;
          if (ry < 0 || ry >= h || cx < 0 || cx >= w) continue;
          addr = (p_rd + LS_DEPTH + dy * w + dx) % LS_DEPTH;
          nb = shadow_store[addr];
          diff = (nb > value) ? nb - value : value - nb;
          n++;
          if (diff < c_tol) similar++;
        end
      end
      flat = n > 0 && similar >= (9 * n + 9) / 10;
    end
    if (c_edge != 0) res.value = flat ? '0 : PIX_MAX;
    else if (!flat) res.value = value;
    else if (value < c_black) res.value = '0;
    else if (value >= c_white) res.value = PIX_MAX;
    else begin
      q = (longint'(value - c_black) * 65535) / longint'(c_white - c_black);
      res.value = q[PIX_W-1:0];
    end
    res.last = (p_out_col + 1 >= w) && (p_out_row + 1 >= h);
    matte_exp.push_back(res);
    p_rd = (p_rd + 1 >= LS_DEPTH) ? 0 : p_rd + 1;
    p_pending--;
    step_pos(p_out_col, p_out_row, w, h);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver: next pending transaction, random sender gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pix_queue.size() > 0 && $urandom_range(99) >= snd_idle) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pix_queue[0].pixel;
        in_tuser  <= pix_queue[0].flush;
        pix_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // monitor: check results, then predict from accepted input
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (matte_exp.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          if (out_tdata !== matte_exp[0].value)
            report_mismatch($sformatf("value %h want %h", out_tdata, matte_exp[0].value));
          if (out_tlast !== matte_exp[0].last)
            report_mismatch($sformatf("last %b want %b", out_tlast, matte_exp[0].last));
          matte_exp.pop_front();
        end
      end
      if (in_tvalid && in_tready) predict_matte(in_tdata, in_tuser);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    case (idx)
      REG_RADIUS:    c_radius = val & 7;
      REG_TOLERANCE: c_tol    = val & 16'hffff;
      REG_BLACK:     c_black  = val & 16'hffff;
      REG_WHITE:     c_white  = val & 16'hffff;
      REG_EDGE:      c_edge   = val & 1;
      REG_WIDTH:     c_width  = val & 12'hfff;
      REG_HEIGHT:    c_height = val & 16'hffff;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (pix_queue.size() == 0 && !in_tvalid && matte_exp.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_frame(int rad, int tol, int blk, int wht, int edg, int w, int h);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_BLACK, blk);
    write_reg(REG_WHITE, wht);
    write_reg(REG_EDGE, edg);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // one complete frame of pixels, with random stray flushes, plus the flushes that drain it
  task automatic queue_frame(int style, int noise);
    int npix, base, v, drains;
    pix_item_t it;
    npix = eff_w() * eff_h();
    base = $urandom_range(65535);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99) < noise) begin
        it.pixel = PIX_W'($urandom);
        it.flush = 1'b1;
        pix_queue.push_back(it);
      end
      case (style)
        0: begin
          v = base + int'($urandom_range(8000)) - 4000;
          v = (v < 0) ? 0 : (v > 65535) ? 65535 : v;
        end
        1: v = $urandom_range(65535);
        default: v = $urandom_range(1) ? 65535 : 0;
      endcase
      it.pixel = v[PIX_W-1:0];
      it.flush = 1'b0;
      pix_queue.push_back(it);
    end
    drains = (npix < eff_lag()) ? npix : eff_lag();
    for (int i = 0; i < drains + 2; i++) begin
      it.pixel = PIX_W'($urandom);
      it.flush = 1'b1;
      pix_queue.push_back(it);
    end
  endtask

  function automatic int pick_edge16();
    case ($urandom_range(3))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  initial begin
    int sent;
    int blk, wht;
    pix_item_t it;
    p_in_col = 0; p_in_row = 0; p_out_col = 0; p_out_row = 0;
    p_wr = 0; p_rd = 0; p_pending = 0;
    c_radius = 3; c_tol = 6554; c_black = 0; c_white = 65535;
    c_edge = 0; c_width = 2048; c_height = 1;
    for (int i = 0; i < LS_DEPTH; i++) shadow_store[i] = '0;
    snd_idle = 11;
    rcv_idle = 68;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: radius zero, radius one, inverted clip, edge mode, clamped sizes
    set_frame(0, 6554, 100, 60000, 0, 3, 2);
    queue_frame(2, 0);
    wait_drained();
    set_frame(1, 65535, 0, 65535, 0, 2, 2);
    queue_frame(1, 0);
    wait_drained();
    set_frame(7, 0, 50000, 1000, 1, 0, 0);
    queue_frame(1, 0);
    wait_drained();
    set_frame(2, 65535, 50000, 1000, 0, 3, 3);
    queue_frame(0, 20);
    wait_drained();

    // tall frame cut short: radius zero reads only the center
    set_frame(0, 6554, 0, 65535, 0, 1, 65535);
    for (int i = 0; i < 12; i++) begin
      it.pixel = PIX_W'($urandom);
      it.flush = 1'b0;
      pix_queue.push_back(it);
    end
    wait_drained();
    write_reg(REG_HEIGHT, 1);
    it.pixel = PIX_W'($urandom);
    it.flush = 1'b0;
    pix_queue.push_back(it);
    wait_drained();

    // random frames, idling pattern changes by thirds
    sent = 0;
    while (sent < 700) begin
      if (sent < 233) begin
        snd_idle = 11; rcv_idle = 68;
      end else if (sent < 466) begin
        snd_idle = 68; rcv_idle = 11;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      blk = pick_edge16();
      wht = pick_edge16();
      if ($urandom_range(3) != 0 && blk > wht) begin
        int t;
        t = blk; blk = wht; wht = t;
      end
      set_frame($urandom_range(9) < 8 ? $urandom_range(2, 4) : $urandom_range(7),
                $urandom_range(4) == 0 ? pick_edge16() : $urandom_range(2000, 9000),
                blk, wht, $urandom_range(1),
                $urandom_range(10) == 0 ? 0 : $urandom_range(1, 9),
                $urandom_range(10) == 0 ? 0 : $urandom_range(1, 6));
      queue_frame($urandom_range(9) < 6 ? 0 : $urandom_range(1, 2), 4);
      sent += pix_queue.size();
      wait_drained();
    end

    // start of a row at the widest size, width field at its top, radius zero
    set_frame(0, 9000, 1000, 64000, 0, 4095, 1);
    for (int i = 0; i < 40; i++) begin
      it.pixel = PIX_W'($urandom);
      it.flush = 1'b0;
      pix_queue.push_back(it);
    end
    wait_drained();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hdl/kec_pkg.sv
hdl/kec_div_cell.sv
hdl/keying_edge_clip_window_top.sv
tb/tb.sv
